// ===== rtl/core/rcmt_pkg.sv =====
package rcmt_pkg;

    localparam int LIMIT      = 15;
    localparam int SLOTS      = LIMIT + 1;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int COUNT_W    = 5;
    localparam int HEAD_W     = 64;
    localparam int TAIL_W     = 8;
    localparam int LEN_W      = 4;
    localparam int STAMP_W    = 32;
    localparam int POS_W      = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEN_W-1:0]   NAME_LEN_MAX = 4'd9;
    localparam logic [COUNT_W-1:0] COUNT_FULL   = COUNT_W'(SLOTS);

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_HIT  = 2'd1,
        ST_MISS = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [HEAD_W-1:0]  head;
        logic [TAIL_W-1:0]  tail;
        logic [LEN_W-1:0]   len;
        logic [STAMP_W-1:0] stamp;
        logic [POS_W-1:0]   pos;
    } cmd_t;

    // Keep character i of the head when it lies below the name length.
    function automatic logic [HEAD_W-1:0] head_mask(input logic [LEN_W-1:0] len);
        logic [HEAD_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            m[HEAD_W-1-8*i -: 8] = (len > LEN_W'(i)) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    function automatic logic [TAIL_W-1:0] tail_mask(input logic [LEN_W-1:0] len);
        return (len >= NAME_LEN_MAX) ? {TAIL_W{1'b1}} : '0;
    endfunction

endpackage

// ===== rtl/core/recent_callsign_mru_table.sv =====
// Most-recently-used callsign table, 16 entries, least recent entry evicted.
// Input channel (in_valid / in_stall) carries one word per item: kind selects
// add (search by prefix, refresh or insert at the front), read at a recency
// position, clear of the new flag, or nothing. Output channel (out_valid /
// out_stall) returns exactly one word per item, in order, with the read entry,
// the last lookup status, the entry count and the new flag.
// A front stage registers and masks the word, a two-entry queue decouples it
// from the table engine, and the engine runs one item at a time.
// An add scans one stored entry per cycle over the held entries through a
// single table read port, then inserts on a miss.
// The engine takes a new item only once the result of the last is loaded.
// Reset empties the table and clears the status and new flag; stored names
// need no clearing since only positions below the count are ever read.
// While out_valid and out_stall are both high the result word holds; the
// engine finishes its current item and waits, and the queue and front stage
// keep accepting until full, after which in_stall rises.
module recent_callsign_mru_table
    import rcmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [HEAD_W-1:0]  callsign_head,
    input  logic [TAIL_W-1:0]  callsign_tail,
    input  logic [LEN_W-1:0]   callsign_length,
    input  logic [STAMP_W-1:0] time_stamp,
    input  logic [POS_W-1:0]   position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               read_ok,
    output logic [HEAD_W-1:0]  entry_head,
    output logic [TAIL_W-1:0]  entry_tail,
    output logic [LEN_W-1:0]   entry_length,
    output logic [STAMP_W-1:0] entry_time,
    output logic [1:0]         lookup_status,
    output logic [COUNT_W-1:0] entry_count,
    output logic               new_flag
);

    logic push_valid;
    cmd_t push_cmd;
    logic q_full;
    logic q_empty;
    cmd_t q_cmd;
    logic pop;

    rcmt_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .callsign_head   (callsign_head),
        .callsign_tail   (callsign_tail),
        .callsign_length (callsign_length),
        .time_stamp      (time_stamp),
        .position        (position),
        .push_valid      (push_valid),
        .push_cmd        (push_cmd),
        .q_full          (q_full)
    );

    rcmt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .pop_cmd    (q_cmd)
    );

    rcmt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_cmd         (q_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_ok       (read_ok),
        .entry_head    (entry_head),
        .entry_tail    (entry_tail),
        .entry_length  (entry_length),
        .entry_time    (entry_time),
        .lookup_status (lookup_status),
        .entry_count   (entry_count),
        .new_flag      (new_flag)
    );

endmodule

// ===== rtl/core/rcmt_front.sv =====
module rcmt_front
    import rcmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [HEAD_W-1:0]  callsign_head,
    input  logic [TAIL_W-1:0]  callsign_tail,
    input  logic [LEN_W-1:0]   callsign_length,
    input  logic [STAMP_W-1:0] time_stamp,
    input  logic [POS_W-1:0]   position,
    output logic               push_valid,
    output cmd_t               push_cmd,
    input  logic               q_full
);

    logic             hold_valid_reg;
    logic             hold_valid_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic             accept;
    logic             push_done;
    logic [LEN_W-1:0] len_sat;

    assign in_stall   = hold_valid_reg & q_full;
    assign accept     = in_valid & ~in_stall;
    assign push_done  = hold_valid_reg & ~q_full;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = cmd_reg;

    // Saturate the length and zero the characters beyond it.
    always_comb
    begin
        len_sat        = (callsign_length > NAME_LEN_MAX) ? NAME_LEN_MAX : callsign_length;
        cmd_next.op    = op_t'(kind);
        cmd_next.len   = len_sat;
        cmd_next.head  = callsign_head & head_mask(len_sat);
        cmd_next.tail  = callsign_tail & tail_mask(len_sat);
        cmd_next.stamp = time_stamp;
        cmd_next.pos   = position;
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_done)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== rtl/core/rcmt_queue.sv =====
module rcmt_queue
    import rcmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t pop_cmd
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              push_en;
    logic              pop_en;

    assign full    = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign push_en = push_valid & ~full;
    assign pop_en  = pop & ~empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_en && !pop_en)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop_en && !push_en)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/rcmt_back.sv =====
module rcmt_back
    import rcmt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  cmd_t                q_cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                read_ok,
    output logic [HEAD_W-1:0]   entry_head,
    output logic [TAIL_W-1:0]   entry_tail,
    output logic [LEN_W-1:0]    entry_length,
    output logic [STAMP_W-1:0]  entry_time,
    output logic [1:0]          lookup_status,
    output logic [COUNT_W-1:0]  entry_count,
    output logic                new_flag
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_INSERT = 5'b00100,
        S_READ   = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    logic [HEAD_W-1:0]  head_mem  [SLOTS];
    logic [TAIL_W-1:0]  tail_mem  [SLOTS];
    logic [LEN_W-1:0]   len_mem   [SLOTS];
    logic [STAMP_W-1:0] stamp_mem [SLOTS];
    logic [SLOT_W-1:0]  order_reg [SLOTS];

    state_t             state_reg;
    state_t             state_next;
    cmd_t               cmd_reg;
    logic [SLOT_W-1:0]  ptr_reg;
    logic [SLOT_W-1:0]  ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               fresh_reg;
    logic               fresh_next;
    status_t            status_reg;
    status_t            status_next;

    logic               res_ok_reg;
    logic               res_ok_next;
    logic [HEAD_W-1:0]  res_head_reg;
    logic [HEAD_W-1:0]  res_head_next;
    logic [TAIL_W-1:0]  res_tail_reg;
    logic [TAIL_W-1:0]  res_tail_next;
    logic [LEN_W-1:0]   res_len_reg;
    logic [LEN_W-1:0]   res_len_next;
    logic [STAMP_W-1:0] res_time_reg;
    logic [STAMP_W-1:0] res_time_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_load;

    logic [SLOT_W-1:0]  rd_pos;
    logic [SLOT_W-1:0]  rd_slot;
    logic               match;
    logic               table_full;
    logic [SLOT_W-1:0]  ins_slot;

    logic               wr_stamp_en;
    logic               wr_entry_en;
    logic [SLOT_W-1:0]  wr_slot;
    logic               front_en;
    logic [SLOT_W-1:0]  front_last;
    logic [SLOT_W-1:0]  front_val;

    assign pop        = (state_reg == S_IDLE) & ~q_empty;
    assign out_load   = (state_reg == S_DONE) & (~out_valid_reg | ~out_stall);
    assign table_full = (count_reg == COUNT_FULL);
    assign ins_slot   = table_full ? order_reg[SLOTS-1] : count_reg[SLOT_W-1:0];

    // One table port: the scan pointer, or the requested position on a read.
    assign rd_pos  = (state_reg == S_READ) ? cmd_reg.pos[SLOT_W-1:0] : ptr_reg;
    assign rd_slot = order_reg[rd_pos];
    assign match   = (len_mem[rd_slot] >= cmd_reg.len)
                   && ((head_mem[rd_slot] & head_mask(cmd_reg.len)) == cmd_reg.head)
                   && ((tail_mem[rd_slot] & tail_mask(cmd_reg.len)) == cmd_reg.tail);

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        count_next    = count_reg;
        fresh_next    = fresh_reg;
        status_next   = status_reg;
        res_ok_next   = res_ok_reg;
        res_head_next = res_head_reg;
        res_tail_next = res_tail_reg;
        res_len_next  = res_len_reg;
        res_time_next = res_time_reg;
        wr_stamp_en   = 1'b0;
        wr_entry_en   = 1'b0;
        wr_slot       = rd_slot;
        front_en      = 1'b0;
        front_last    = ptr_reg;
        front_val     = rd_slot;

        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    res_ok_next   = 1'b0;
                    res_head_next = '0;
                    res_tail_next = '0;
                    res_len_next  = '0;
                    res_time_next = '0;
                    ptr_next      = '0;
                    case (q_cmd.op)
                        OP_ADD:
                        begin
                            fresh_next = 1'b1;
                            state_next = (count_reg == '0) ? S_INSERT : S_SCAN;
                        end
                        OP_READ:
                        begin
                            state_next = S_READ;
                        end
                        OP_CLEAR:
                        begin
                            fresh_next = 1'b0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    // Refresh the stamp and move the hit to the front.
                    status_next = ST_HIT;
                    wr_stamp_en = 1'b1;
                    front_en    = 1'b1;
                    state_next  = S_DONE;
                end
                else if ({1'b0, ptr_reg} + 5'd1 == count_reg)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_INSERT:
            begin
                // Reuse the least recent slot when full, else take a fresh one.
                status_next = ST_MISS;
                wr_entry_en = 1'b1;
                wr_slot     = ins_slot;
                front_en    = 1'b1;
                front_last  = table_full ? SLOT_W'(SLOTS - 1) : count_reg[SLOT_W-1:0];
                front_val   = ins_slot;
                count_next  = table_full ? count_reg : count_reg + 1'b1;
                state_next  = S_DONE;
            end
            S_READ:
            begin
                if (cmd_reg.pos < {3'b000, count_reg})
                begin
                    res_ok_next   = 1'b1;
                    res_head_next = head_mem[rd_slot];
                    res_tail_next = tail_mem[rd_slot];
                    res_len_next  = len_mem[rd_slot];
                    res_time_next = stamp_mem[rd_slot];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            count_reg     <= '0;
            fresh_reg     <= 1'b0;
            status_reg    <= ST_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_ok_reg   <= res_ok_next;
        res_head_reg <= res_head_next;
        res_tail_reg <= res_tail_next;
        res_len_reg  <= res_len_next;
        res_time_reg <= res_time_next;
        if (pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (wr_entry_en)
        begin
            head_mem[wr_slot] <= cmd_reg.head;
            tail_mem[wr_slot] <= cmd_reg.tail;
            len_mem[wr_slot]  <= cmd_reg.len;
        end
        if (wr_stamp_en || wr_entry_en)
        begin
            stamp_mem[wr_slot] <= cmd_reg.stamp;
        end
        // Shift positions 0..front_last-1 down by one, put front_val on top.
        if (front_en)
        begin
            for (int i = 1; i < SLOTS; i++)
            begin
                if (SLOT_W'(i) <= front_last)
                begin
                    order_reg[i] <= order_reg[i-1];
                end
            end
            order_reg[0] <= front_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            read_ok       <= res_ok_reg;
            entry_head    <= res_head_reg;
            entry_tail    <= res_tail_reg;
            entry_length  <= res_len_reg;
            entry_time    <= res_time_reg;
            lookup_status <= status_reg;
            entry_count   <= count_reg;
            new_flag      <= fresh_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_FULL)
        else $error("entry count above table size");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg >= $past(count_reg))
        else $error("entry count decreased");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ({1'b0, ptr_reg} < count_reg))
        else $error("scan pointer beyond held entries");

    a_add_sets_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && cmd_reg.op == OP_ADD) |-> (status_reg != ST_NONE))
        else $error("add finished without a lookup status");

endmodule

// ===== test/tb_recent_callsign_mru_table.sv =====
`timescale 1ns / 100ps

module tb_recent_callsign_mru_table;
    import rcmt_pkg::*;

    localparam int QUIET_TAIL = 60;
    localparam int POOL_SIZE  = 24;

    typedef struct {
        op_t                op;
        logic [HEAD_W-1:0]  head;
        logic [TAIL_W-1:0]  tail;
        logic [LEN_W-1:0]   len;
        logic [STAMP_W-1:0] stamp;
        logic [POS_W-1:0]   pos;
        bit                 hold_off;
    } stim_t;

    typedef struct {
        logic               ok;
        logic [HEAD_W-1:0]  head;
        logic [TAIL_W-1:0]  tail;
        logic [LEN_W-1:0]   len;
        logic [STAMP_W-1:0] stamp;
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic               fresh;
    } table_word_t;

    logic               clk             = 1'b0;
    logic               rst_n           = 1'b0;
    logic               in_valid        = 1'b0;
    logic               in_stall;
    logic [1:0]         kind            = '0;
    logic [HEAD_W-1:0]  callsign_head   = '0;
    logic [TAIL_W-1:0]  callsign_tail   = '0;
    logic [LEN_W-1:0]   callsign_length = '0;
    logic [STAMP_W-1:0] time_stamp      = '0;
    logic [POS_W-1:0]   position        = '0;
    logic               out_valid;
    logic               out_stall       = 1'b0;
    logic               read_ok;
    logic [HEAD_W-1:0]  entry_head;
    logic [TAIL_W-1:0]  entry_tail;
    logic [LEN_W-1:0]   entry_length;
    logic [STAMP_W-1:0] entry_time;
    logic [1:0]         lookup_status;
    logic [COUNT_W-1:0] entry_count;
    logic               new_flag;

    recent_callsign_mru_table dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .callsign_head   (callsign_head),
        .callsign_tail   (callsign_tail),
        .callsign_length (callsign_length),
        .time_stamp      (time_stamp),
        .position        (position),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_ok         (read_ok),
        .entry_head      (entry_head),
        .entry_tail      (entry_tail),
        .entry_length    (entry_length),
        .entry_time      (entry_time),
        .lookup_status   (lookup_status),
        .entry_count     (entry_count),
        .new_flag        (new_flag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stim_t       queued_items[$];
    table_word_t mru_answers[$];
    stim_t       cur_item;
    table_word_t want;
    int          mismatches = 0;
    int          send_gap;
    int          stall_left;

    // Predictor state: the table, its recency order and the flags.
    logic [HEAD_W-1:0]  tbl_head  [SLOTS];
    logic [TAIL_W-1:0]  tbl_tail  [SLOTS];
    logic [LEN_W-1:0]   tbl_len   [SLOTS];
    logic [STAMP_W-1:0] tbl_stamp [SLOTS];
    int                 tbl_order [SLOTS];
    int                 tbl_held  = 0;
    logic               tbl_fresh = 1'b0;
    status_t            tbl_status = ST_NONE;

    // Callsigns reused by the random part so that refreshes and evictions occur.
    logic [HEAD_W-1:0]  pool_head [POOL_SIZE];
    logic [TAIL_W-1:0]  pool_tail [POOL_SIZE];
    int                 pool_len  [POOL_SIZE];

    task automatic bring_to_front(input int p);
        int slot;
        slot = tbl_order[p];
        for (int q = p; q > 0; q--)
        begin
            tbl_order[q] = tbl_order[q-1];
        end
        tbl_order[0] = slot;
    endtask

    task automatic mru_predict(input stim_t it);
        table_word_t        w;
        int                 n;
        int                 slot;
        bit                 hit;
        logic [HEAD_W-1:0]  hm;
        logic [TAIL_W-1:0]  tm;
        logic [HEAD_W-1:0]  h;
        logic [TAIL_W-1:0]  t;
        w = '{ok: 1'b0, head: '0, tail: '0, len: '0, stamp: '0,
              status: ST_NONE, count: '0, fresh: 1'b0};
        n = (it.len > 9) ? 9 : int'(it.len);
        hm = ~({HEAD_W{1'b1}} >> (8 * n));
        tm = (n >= 9) ? {TAIL_W{1'b1}} : '0;
        h = it.head & hm;
        t = it.tail & tm;
        hit = 1'b0;
        case (it.op)
            OP_ADD:
            begin
                tbl_fresh = 1'b1;
                for (int p = 0; p < tbl_held && !hit; p++)
                begin
                    slot = tbl_order[p];
                    if (tbl_len[slot] >= n && (tbl_head[slot] & hm) == h &&
                        (tbl_tail[slot] & tm) == t)
                    begin
                        hit = 1'b1;
                        tbl_stamp[slot] = it.stamp;
                        bring_to_front(p);
                    end
                end
                if (hit)
                begin
                    tbl_status = ST_HIT;
                end
                else
                begin
                    tbl_status = ST_MISS;
                    if (tbl_held >= SLOTS)
                    begin
                        slot = tbl_order[SLOTS-1];
                    end
                    else
                    begin
                        slot = tbl_held;
                        tbl_order[tbl_held] = slot;
                        tbl_held++;
                    end
                    tbl_head[slot]  = h;
                    tbl_tail[slot]  = t;
                    tbl_len[slot]   = LEN_W'(n);
                    tbl_stamp[slot] = it.stamp;
                    bring_to_front(tbl_held - 1);
                end
            end
            OP_READ:
            begin
                if (int'(it.pos) < tbl_held)
                begin
                    slot = tbl_order[it.pos];
                    w.ok    = 1'b1;
                    w.head  = tbl_head[slot];
                    w.tail  = tbl_tail[slot];
                    w.len   = tbl_len[slot];
                    w.stamp = tbl_stamp[slot];
                end
            end
            OP_CLEAR:
            begin
                tbl_fresh = 1'b0;
            end
            default:
            begin
            end
        endcase
        w.status = tbl_status;
        w.count  = COUNT_W'(tbl_held);
        w.fresh  = tbl_fresh;
        mru_answers.push_back(w);
    endtask

    task automatic check_field(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic push_item(input op_t op, input logic [HEAD_W-1:0] head,
                             input logic [TAIL_W-1:0] tail, input logic [LEN_W-1:0] len,
                             input logic [STAMP_W-1:0] stamp, input logic [POS_W-1:0] pos,
                             input bit hold_off);
        stim_t it;
        it = '{op: op, head: head, tail: tail, len: len, stamp: stamp, pos: pos,
               hold_off: hold_off};
        queued_items.push_back(it);
    endtask

    // Fields that an item ignores still get random content.
    task automatic push_add(input logic [HEAD_W-1:0] head, input logic [TAIL_W-1:0] tail,
                            input int len);
        push_item(OP_ADD, head, tail, LEN_W'(len), $urandom,
                  POS_W'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic push_op(input op_t op, input int pos);
        push_item(op, {$urandom, $urandom}, TAIL_W'($urandom),
                  LEN_W'($urandom_range(0, 15)), $urandom, POS_W'(pos), 1'b0);
    endtask

    function automatic logic [7:0] rand_char();
        int v;
        v = $urandom_range(0, 35);
        if ($urandom_range(0, 19) == 0)
            return 8'($urandom);
        return (v < 26) ? 8'h41 + 8'(v) : 8'h30 + 8'(v - 26);
    endfunction

    task automatic fresh_name(input int idx);
        logic [8*9-1:0] chars;
        pool_len[idx] = $urandom_range(1, 9);
        for (int i = 0; i < 9; i++)
        begin
            chars[8*(8-i) +: 8] = (i < pool_len[idx]) ? rand_char() : 8'($urandom);
        end
        pool_head[idx] = chars[8*9-1:8];
        pool_tail[idx] = chars[7:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                mru_predict(cur_item);
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (queued_items.size() == 0 ||
                     (queued_items[0].hold_off && mru_answers.size() != 0))
            begin
                // hold until the table has answered everything in flight
                in_valid <= 1'b0;
            end
            else if (queued_items.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
            begin
                send_gap <= $urandom_range(1, 14) - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                cur_item = queued_items.pop_front();
                in_valid        <= 1'b1;
                kind            <= cur_item.op;
                callsign_head   <= cur_item.head;
                callsign_tail   <= cur_item.tail;
                callsign_length <= cur_item.len;
                time_stamp      <= cur_item.stamp;
                position        <= cur_item.pos;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (mru_answers.size() == 0)
                begin
                    $display("%0t: word with nothing expected, expected none actual %0h",
                             $time, entry_head);
                    mismatches++;
                end
                else
                begin
                    want = mru_answers.pop_front();
                    check_field("read_ok", want.ok, read_ok);
                    check_field("entry_head", want.head, entry_head);
                    check_field("entry_tail", want.tail, entry_tail);
                    check_field("entry_length", want.len, entry_length);
                    check_field("entry_time", want.stamp, entry_time);
                    check_field("lookup_status", want.status, lookup_status);
                    check_field("entry_count", want.count, entry_count);
                    check_field("new_flag", want.fresh, new_flag);
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else if (queued_items.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(1, 14) - 1;
                out_stall  <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        int sel;
        int idx;
        int n;
        for (int i = 0; i < POOL_SIZE; i++)
            fresh_name(i);

        // empty table: out-of-range read, unused kind, clear
        push_op(OP_READ, 0);
        push_op(OP_NOP, 0);
        push_op(OP_CLEAR, 0);
        // zero-length name, then a full name that a stored short name cannot match
        push_add({$urandom, $urandom}, TAIL_W'($urandom), 0);
        push_item(OP_ADD, '1, '1, 4'd9, '1, '1, 1'b0);
        // length above nine saturates and hits the full name
        push_item(OP_ADD, '1, '1, 4'd15, '0, '0, 1'b0);
        // prefix of three characters hits the full name, the rest is ignored
        push_add({24'hFFFFFF, 8'($urandom), {$urandom}}, TAIL_W'($urandom), 3);
        // zero length matches the most recent entry
        push_add({$urandom, $urandom}, TAIL_W'($urandom), 0);
        push_op(OP_READ, 0);
        push_op(OP_READ, 1);
        push_op(OP_READ, 2);
        push_op(OP_READ, 255);
        push_op(OP_CLEAR, 0);
        push_op(OP_READ, 0);
        push_op(OP_NOP, 0);
        // tail is not part of a name of eight characters
        push_add('0, TAIL_W'($urandom | 1), 8);
        push_add({32'h0, $urandom}, TAIL_W'($urandom), 4);
        push_op(OP_READ, 0);
        push_op(OP_READ, 1);
        push_op(OP_READ, 2);
        push_op(OP_NOP, 0);

        for (int k = 0; k < 700; k++)
        begin
            sel = $urandom_range(0, 99);
            idx = $urandom_range(0, POOL_SIZE - 1);
            if ($urandom_range(0, 29) == 0)
                fresh_name(idx);
            if (sel < 45)
            begin
                n = pool_len[idx];
                if (n == 9 && $urandom_range(0, 3) == 0)
                    n = $urandom_range(9, 15);
                push_add(pool_head[idx], pool_tail[idx], n);
            end
            else if (sel < 55)
            begin
                push_add(pool_head[idx] ^ ({$urandom, $urandom} >> (8 * pool_len[idx])),
                         TAIL_W'($urandom), $urandom_range(0, pool_len[idx]));
            end
            else if (sel < 60)
            begin
                push_add({$urandom, $urandom}, TAIL_W'($urandom), $urandom_range(0, 15));
            end
            else if (sel < 85)
            begin
                push_op(OP_READ, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 17));
            end
            else if (sel < 95)
            begin
                push_op(OP_CLEAR, $urandom_range(0, 255));
            end
            else
            begin
                push_op(OP_NOP, $urandom_range(0, 255));
            end
            if (k % 200 == 100)
                queued_items[queued_items.size() - 1].hold_off = 1'b1;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (queued_items.size() != 0 || in_valid || mru_answers.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rcmt_pkg.sv
rtl/core/rcmt_front.sv
rtl/core/rcmt_queue.sv
rtl/core/rcmt_back.sv
rtl/core/recent_callsign_mru_table.sv
test/tb_recent_callsign_mru_table.sv
